// File: src/mst_pkg.sv
`default_nettype none
package mst_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;

  localparam logic [4:0] EV_SYN = 5'd0;
  localparam logic [4:0] EV_ABS = 5'd3;
  localparam logic [9:0] CODE_REPORT = 10'h000;
  localparam logic [9:0] CODE_SLOT = 10'h02f;
  localparam logic [9:0] CODE_X = 10'h035;
  localparam logic [9:0] CODE_Y = 10'h036;
  localparam logic [9:0] CODE_ID = 10'h039;

  localparam logic [2:0] REG_XMIN = 3'd0;
  localparam logic [2:0] REG_XMAX = 3'd1;
  localparam logic [2:0] REG_YMIN = 3'd2;
  localparam logic [2:0] REG_YMAX = 3'd3;
  localparam logic [2:0] REG_W = 3'd4;
  localparam logic [2:0] REG_H = 3'd5;
  localparam logic [2:0] REG_ROT = 3'd6;

  typedef enum logic [1:0] {
    OP_SLOT, OP_X, OP_Y, OP_ID
  } op_t;

  // Queue entry from the front end: an axis update or a frame request.
  typedef struct packed {
    logic        sync;
    op_t         op;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [15:0] x_min;
    logic [15:0] x_max;
    logic [15:0] y_min;
    logic [15:0] y_max;
    logic [11:0] width;
    logic [11:0] height;
    logic [1:0]  rot;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DIVX, ST_DIVY, ST_EMIT
  } back_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) return 16'sh7fff;
    if (v < -50'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

// File: src/mst_front.sv
`default_nettype none
module mst_front import mst_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [4:0] ev_type,
  input  wire  [9:0] ev_code,
  input  wire [31:0] ev_value,
  output logic       q_valid,
  input  wire        q_ready,
  output cmd_t       q_data
);
  // Two-entry queue; irrelevant events are dropped at the door.
  cmd_t q_r [2];
  cmd_t q_nxt_entry;
  logic [1:0] cnt_r, cnt_nxt;
  logic wr_ptr_r, rd_ptr_r;
  logic keep, push, pop;

  always_comb begin
    keep = 1'b1;
    q_nxt_entry = '{sync: 1'b0, op: OP_SLOT, value: ev_value};
    if (ev_type == EV_ABS) begin
      unique case (ev_code)
        CODE_SLOT: q_nxt_entry.op = OP_SLOT;
        CODE_X:    q_nxt_entry.op = OP_X;
        CODE_Y:    q_nxt_entry.op = OP_Y;
        CODE_ID:   q_nxt_entry.op = OP_ID;
        default:   keep = 1'b0;
      endcase
    end else if (ev_type == EV_SYN && ev_code == CODE_REPORT) begin
      q_nxt_entry.sync = 1'b1;
    end else begin
      keep = 1'b0;
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_r[rd_ptr_r];
  assign pop = q_valid && q_ready;
  assign push = in_tvalid && in_tready && keep;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
    end
    if (push) q_r[wr_ptr_r] <= q_nxt_entry;
  end
endmodule
`default_nettype wire

// File: src/mst_div.sv
`default_nettype none
module mst_div import mst_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire signed [49:0] num,
  input  wire signed [17:0] den,
  output logic              done,
  output logic signed [49:0] quot
);
  // Restoring divide on magnitudes, one quotient bit per cycle, truncating.
  logic [49:0] q_r, q_nxt;
  logic [49:0] rem_r, rem_nxt;
  logic [16:0] d_r;
  logic neg_r, busy_r;
  logic [5:0] cnt_r;
  logic [50:0] trial;
  logic [49:0] anum;
  logic [17:0] aden;

  assign anum = num[49] ? 50'(-num) : num;
  assign aden = den[17] ? 18'(-den) : den;
  assign trial = {rem_r, q_r[49]} - {34'd0, d_r};

  always_comb begin
    if (!trial[50]) begin
      rem_nxt = trial[49:0];
      q_nxt = {q_r[48:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[48:0], q_r[49]};
      q_nxt = {q_r[48:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= busy_r && !start && (cnt_r == 6'd1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd50;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) busy_r <= 1'b0;
      end
    end
    if (start) begin
      q_r <= anum;
      rem_r <= '0;
      d_r <= aden[16:0];
      neg_r <= num[49] ^ den[17];
    end else if (busy_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = neg_r ? 50'(-q_r) : q_r;
endmodule
`default_nettype wire

// File: src/mst_back.sv
`default_nettype none
module mst_back import mst_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  cfg_t       cfg,
  input  wire        q_valid,
  output logic       q_ready,
  input  cmd_t       q_data,
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [68:0] out_payload,
  output logic       out_last
);
  logic [31:0] sel_r;
  logic [31:0] sx_r [SLOTS];
  logic [31:0] sy_r [SLOTS];
  logic [31:0] sid_r [SLOTS];
  logic [SLOTS-1:0] act_r;

  back_state_t st_r, st_nxt;
  logic [SLOT_W-1:0] idx_r;
  logic any_r;
  logic signed [15:0] px_r, py_r;
  logic signed [15:0] ox_r, oy_r;
  logic oval_r, olast_r;
  logic [SLOT_W-1:0] oslot_r;
  logic [31:0] oid_r;
  logic ovalid_r;

  // Divider operands for the current slot and axis.
  logic div_start, div_done;
  logic signed [49:0] div_num, div_q;
  logic signed [17:0] div_den;
  logic signed [33:0] dxx, dyy, rxx, ryy;
  logic pass, ax_y_src, ax_y_compl, bx_y_src, bx_y_compl;
  logic signed [33:0] d_sel, r_sel;
  logic signed [13:0] size_sel;
  logic compl_sel, src_y;
  logic signed [15:0] term16;
  logic [SLOTS-1:0] later;
  logic emit_go;

  mst_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .done(div_done), .quot(div_q));

  assign pass = (cfg.width == 12'd0) || (cfg.height == 12'd0);
  assign dxx = $signed(sx_r[idx_r]) - $signed({18'd0, cfg.x_min});
  assign dyy = $signed(sy_r[idx_r]) - $signed({18'd0, cfg.y_min});
  assign rxx = $signed({18'd0, cfg.x_max}) - $signed({18'd0, cfg.x_min});
  assign ryy = $signed({18'd0, cfg.y_max}) - $signed({18'd0, cfg.y_min});

  // Screen X uses Y input for rotations 90/270; complement per rotation.
  assign ax_y_src = cfg.rot[0];
  assign ax_y_compl = (cfg.rot == 2'd2) || (cfg.rot == 2'd3);
  assign bx_y_src = !cfg.rot[0];
  assign bx_y_compl = (cfg.rot == 2'd1) || (cfg.rot == 2'd2);

  always_comb begin
    src_y = (st_r == ST_DIVX) ? ax_y_src : bx_y_src;
    compl_sel = (st_r == ST_DIVX) ? ax_y_compl : bx_y_compl;
    size_sel = (st_r == ST_DIVX) ? $signed({2'b0, cfg.width}) : $signed({2'b0, cfg.height});
    d_sel = src_y ? dyy : dxx;
    r_sel = src_y ? ryy : rxx;
    div_num = 50'(size_sel * (compl_sel ? (r_sel - d_sel) : d_sel));
    div_den = r_sel[17:0];
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) later[i] = act_r[i] && (SLOT_W'(i) > idx_r);
  end

  always_comb begin
    if (r_sel == 34'sd0) term16 = compl_sel ? $signed({4'd0, size_sel[11:0]}) : 16'sd0;
    else term16 = sat16(div_q);
  end

  logic div_pending_r;
  assign q_ready = (st_r == ST_IDLE);
  assign div_start = (st_r == ST_DIVX || st_r == ST_DIVY) && !div_pending_r && !pass
                     && r_sel != 34'sd0;
  assign emit_go = (st_r == ST_EMIT) && (!ovalid_r || out_tready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid && q_data.sync) st_nxt = ST_SCAN;
      ST_SCAN: if (act_r[idx_r]) st_nxt = ST_DIVX;
               else if (idx_r == SLOT_W'(SLOTS-1) && any_r) st_nxt = ST_IDLE;
               else if (idx_r == SLOT_W'(SLOTS-1)) st_nxt = ST_EMIT;
      ST_DIVX: if (pass || r_sel == 34'sd0 || div_done) st_nxt = ST_DIVY;
      ST_DIVY: if (pass || r_sel == 34'sd0 || div_done) st_nxt = ST_EMIT;
      ST_EMIT: if (!ovalid_r || out_tready) st_nxt =
                 (!act_r[idx_r] || later == '0) ? ST_IDLE : ST_SCAN;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Points are staged in px/py so a stalled beat keeps its data while the next
  // slot is mapped; the emit state copies them once the output register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      sel_r <= '0;
      act_r <= '0;
      idx_r <= '0;
      any_r <= 1'b0;
      ovalid_r <= 1'b0;
      div_pending_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        sx_r[i] <= '0; sy_r[i] <= '0; sid_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (emit_go) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      if (st_r != st_nxt) div_pending_r <= 1'b0;
      else if (div_start) div_pending_r <= 1'b1;
      unique case (st_r)
        ST_IDLE: begin
          idx_r <= '0;
          any_r <= 1'b0;
          if (q_valid && !q_data.sync) begin
            if (q_data.op == OP_SLOT) sel_r <= q_data.value;
            else if (sel_r < 32'(SLOTS)) begin
              case (q_data.op)
                OP_X: sx_r[sel_r[SLOT_W-1:0]] <= q_data.value;
                OP_Y: sy_r[sel_r[SLOT_W-1:0]] <= q_data.value;
                OP_ID: if (q_data.value == 32'hffffffff) act_r[sel_r[SLOT_W-1:0]] <= 1'b0;
                       else begin
                         act_r[sel_r[SLOT_W-1:0]] <= 1'b1;
                         sid_r[sel_r[SLOT_W-1:0]] <= q_data.value;
                       end
                default: ;
              endcase
            end
          end
        end
        ST_SCAN: if (!act_r[idx_r] && idx_r != SLOT_W'(SLOTS-1)) idx_r <= idx_r + 1'b1;
        ST_DIVX: if (st_nxt != st_r)
                   px_r <= pass ? sat16(50'($signed(sx_r[idx_r]))) : term16;
        ST_DIVY: if (st_nxt != st_r)
                   py_r <= pass ? sat16(50'($signed(sy_r[idx_r]))) : term16;
        ST_EMIT: if (emit_go) begin
          oval_r <= act_r[idx_r];
          oslot_r <= act_r[idx_r] ? idx_r : '0;
          oid_r <= act_r[idx_r] ? sid_r[idx_r] : '0;
          ox_r <= act_r[idx_r] ? px_r : 16'sd0;
          oy_r <= act_r[idx_r] ? py_r : 16'sd0;
          olast_r <= !act_r[idx_r] || (later == '0);
          any_r <= 1'b1;
          if (idx_r != SLOT_W'(SLOTS-1)) idx_r <= idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_payload = {oy_r, ox_r, oid_r, oslot_r, oval_r};
  assign out_last = olast_r;
endmodule
`default_nettype wire

// File: src/multitouch_slot_tracker.sv
`default_nettype none
// Channel | Beat fields (low bit first)                           | Handshake
// in      | tuser: event_type, event_code; tdata: event_value     | in_tvalid/in_tready
// out     | tuser: point_valid; tdata: slot, id, screen_x,        | out_tvalid/out_tready
//         | screen_y, pad; tlast: frame_last                      |
// cfg     | index 0..6, data 16 bits                              | cfg_we
// An axis beat leaves the two-entry queue while the back end is idle.
// A sync beat costs an idle state, a scan state per slot visited and an emit
// state per point, plus two 50-step divides per active slot; an axis that passes
// raw values through or has a zero range skips its divide.
// Reset is synchronous, active low; slot table cleared, max range regs to 4095, min regs to 0.
// Input stalls when the queue is full while a frame is walked; output stalls hold
// the emit state and, through it, the queue.
module multitouch_slot_tracker import mst_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [14:0] in_tuser,   // event_type[4:0], event_code[14:5]
  input  wire  [31:0] in_tdata,   // event_value
  input  wire         out_tready,
  output logic        out_tvalid,
  output logic        out_tuser,  // point_valid
  output logic [71:0] out_tdata,  // slot_number, contact_id, screen_x, screen_y, pad
  output logic        out_tlast,  // frame_last
  input  wire         cfg_we,
  input  wire   [2:0] cfg_index,
  input  wire  [15:0] cfg_data
);
  cfg_t cfg_r;
  logic q_valid, q_ready;
  cmd_t q_data;
  logic [68:0] payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{x_min: 16'd0, x_max: 16'd4095, y_min: 16'd0, y_max: 16'd4095,
                 width: 12'd0, height: 12'd0, rot: 2'd0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_XMIN: cfg_r.x_min <= cfg_data;
        REG_XMAX: cfg_r.x_max <= cfg_data;
        REG_YMIN: cfg_r.y_min <= cfg_data;
        REG_YMAX: cfg_r.y_max <= cfg_data;
        REG_W:    cfg_r.width <= cfg_data[11:0];
        REG_H:    cfg_r.height <= cfg_data[11:0];
        REG_ROT:  cfg_r.rot <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  mst_front u_front (.clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .ev_type(in_tuser[4:0]), .ev_code(in_tuser[14:5]), .ev_value(in_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

  mst_back u_back (.clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid),
    .q_ready(q_ready), .q_data(q_data), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_payload(payload), .out_last(out_tlast));

  assign out_tuser = payload[0];
  assign out_tdata = {4'd0, payload[68:1]};
endmodule
`default_nettype wire

// File: src/mst_checker.sv
`default_nettype none
module mst_checker (
  input wire clk,
  input wire rst_n,
  input wire out_tvalid,
  input wire out_tready,
  input wire out_tuser,
  input wire [71:0] out_tdata,
  input wire out_tlast
);
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast) else $error("empty frame not last");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0) else $error("empty nonzero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
    && $stable(out_tlast)) else $error("drop");
endmodule
bind multitouch_slot_tracker mst_checker u_chk (.clk(clk), .rst_n(rst_n),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
  .out_tdata(out_tdata), .out_tlast(out_tlast));
`default_nettype wire
